// ===== rtl/core/ndp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ndp_pkg;

  // Largest image side that the block handles, and the widths that follow from it.
  localparam int MAX_DIM = 4096;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int CH_W    = 8;

  // Configuration port.
  localparam int CFG_W     = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_SIZE      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOURCE_HEIGHT = 2'd2;
  localparam logic [CFG_W-1:0]     BOX_SIZE_RST      = 13'd256;
  localparam logic [CFG_W-1:0]     SOURCE_DIM_RST    = 13'd1;

  // Depth of the queue between front and back.
  localparam int QUEUE_DEPTH = 4;

  // Shared divider: the size rounding needs 2*short*box + long over 2*long.
  localparam int DIV_NUM_W = 2 * DIM_W;
  localparam int DIV_DEN_W = DIM_W + 1;

  typedef struct packed {
    logic [CH_W-1:0] red_in;
    logic [CH_W-1:0] green_in;
    logic [CH_W-1:0] blue_in;
    logic [CH_W-1:0] alpha_in;
  } pixel_in_t;

  typedef struct packed {
    logic [CH_W-1:0] blue_out;
    logic [CH_W-1:0] green_out;
    logic [CH_W-1:0] red_out;
    logic [CH_W-1:0] alpha_out;
    logic            row_end;
    logic            frame_end;
  } pixel_out_t;

  // One request as classified by the front: position, row end and the frame sizes.
  typedef struct packed {
    pixel_in_t        pix;
    logic [POS_W-1:0] col;
    logic [POS_W-1:0] row;
    logic             last_col;
    logic [DIM_W-1:0] frame_w;
    logic [DIM_W-1:0] frame_h;
    logic [DIM_W-1:0] box;
  } q_entry_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIV_NUM_W-1:0] quot;
    logic [DIV_DEN_W-1:0] rem;
  } div_rsp_t;

  typedef enum logic [2:0] {
    ST_PIXEL,
    ST_SCALE,
    ST_SCALE_WAIT,
    ST_COL,
    ST_COL_WAIT,
    ST_ROW,
    ST_ROW_WAIT
  } back_state_t;

endpackage

`default_nettype wire

// ===== rtl/core/ndp_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ndp_queue #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign empty = (count_r == '0);
  assign full  = (count_r == CNT_W'(DEPTH));
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndp_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ndp_front (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire ndp_pkg::pixel_in_t                in_data,
  input  wire logic                              cfg_we,
  input  wire logic [ndp_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [ndp_pkg::CFG_W-1:0]         cfg_wdata,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output ndp_pkg::q_entry_t                      q_wdata
);

  import ndp_pkg::*;

  // Zero counts as one, anything above the largest side counts as that side.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] res;
    if (v == '0) begin
      res = DIM_W'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      res = DIM_W'(MAX_DIM);
    end else begin
      res = DIM_W'(v);
    end
    return res;
  endfunction

  logic [CFG_W-1:0] box_size_r, source_width_r, source_height_r;
  logic [POS_W-1:0] col_r, col_nxt;
  logic [POS_W-1:0] row_r, row_nxt;
  logic [DIM_W-1:0] frame_w_r, frame_h_r, box_r;
  logic [DIM_W-1:0] fw, fh, fb;
  logic             frame_start, last_col, last_row, accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;

  always_comb begin
    frame_start = (col_r == '0) && (row_r == '0);
    fw = frame_start ? clamp_dim(source_width_r)  : frame_w_r;
    fh = frame_start ? clamp_dim(source_height_r) : frame_h_r;
    fb = frame_start ? clamp_dim(box_size_r)      : box_r;
    last_col = ({1'b0, col_r} + DIM_W'(1)) >= fw;
    last_row = ({1'b0, row_r} + DIM_W'(1)) >= fh;
    col_nxt = last_col ? '0 : col_r + POS_W'(1);
    row_nxt = row_r;
    if (last_col) begin
      row_nxt = last_row ? '0 : row_r + POS_W'(1);
    end
    q_wdata.pix      = in_data;
    q_wdata.col      = col_r;
    q_wdata.row      = row_r;
    q_wdata.last_col = last_col;
    q_wdata.frame_w  = fw;
    q_wdata.frame_h  = fh;
    q_wdata.box      = fb;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_size_r      <= BOX_SIZE_RST;
      source_width_r  <= SOURCE_DIM_RST;
      source_height_r <= SOURCE_DIM_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_BOX_SIZE:      box_size_r      <= cfg_wdata;
        CFG_SOURCE_WIDTH:  source_width_r  <= cfg_wdata;
        CFG_SOURCE_HEIGHT: source_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      frame_w_r <= '0;
      frame_h_r <= '0;
      box_r     <= '0;
    end else if (accept) begin
      col_r     <= col_nxt;
      row_r     <= row_nxt;
      frame_w_r <= fw;
      frame_h_r <= fh;
      box_r     <= fb;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ndp_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire ndp_pkg::div_req_t req,
  output ndp_pkg::div_rsp_t      rsp
);

  import ndp_pkg::*;

  localparam int CNT_W = $clog2(DIV_NUM_W);

  logic                 busy_r, done_r;
  logic [CNT_W-1:0]     cnt_r;
  logic [DIV_NUM_W-1:0] num_r;
  logic [DIV_DEN_W-1:0] den_r, rem_r, rem_step;
  logic [DIV_DEN_W:0]   shifted, diff;
  logic                 qbit, last_step;

  // Restoring division, one quotient bit per cycle; the quotient shifts into num_r.
  always_comb begin
    shifted   = {rem_r, num_r[DIV_NUM_W-1]};
    diff      = shifted - {1'b0, den_r};
    qbit      = shifted >= {1'b0, den_r};
    rem_step  = qbit ? diff[DIV_DEN_W-1:0] : shifted[DIV_DEN_W-1:0];
    last_step = busy_r && (cnt_r == CNT_W'(DIV_NUM_W - 1));
  end

  assign rsp.done = done_r;
  assign rsp.quot = num_r;
  assign rsp.rem  = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= last_step;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (last_step) begin
          busy_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      num_r <= req.num;
      den_r <= req.den;
      rem_r <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[DIV_NUM_W-2:0], qbit};
      rem_r <= rem_step;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ndp_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ndp_back (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              q_empty,
  input  wire ndp_pkg::q_entry_t q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output ndp_pkg::pixel_out_t    out_data,
  output ndp_pkg::div_req_t      div_req,
  input  wire ndp_pkg::div_rsp_t div_rsp
);

  import ndp_pkg::*;

  // Truncating c*a/255 through a reciprocal: exact over the full 8-bit product range.
  function automatic logic [CH_W-1:0] premul(input logic [CH_W-1:0] c,
                                              input logic [CH_W-1:0] a);
    logic [2*CH_W-1:0] prod;
    logic [2*CH_W:0]   y, s;
    prod = (2*CH_W)'(c) * (2*CH_W)'(a);
    y    = {1'b0, prod} + (2*CH_W+1)'(1);
    s    = y + (y >> CH_W);
    return s[2*CH_W-1:CH_W];
  endfunction

  back_state_t state_r, state_nxt;
  logic        setup_done_r, setup_done_nxt;
  logic        out_valid_r, out_valid_nxt;
  pixel_out_t  out_data_r, out_data_nxt;

  logic [DIM_W-1:0]   fw_r, fh_r, fb_r, fw_nxt, fh_nxt, fb_nxt;
  logic               wide_r, scale_r, wide_nxt, scale_nxt;
  logic [DIM_W-1:0]   long_r, long_nxt;
  logic [DIV_NUM_W-1:0] prod_r, prod_nxt;
  logic [DIM_W-1:0]   tw_r, th_r, tw_nxt, th_nxt;
  logic [POS_W-1:0]   col_q_r, col_rm_r, row_q_r, row_rm_r;
  logic [POS_W-1:0]   col_q_nxt, col_rm_nxt, row_q_nxt, row_rm_nxt;

  logic [POS_W-1:0]   npc_r, npc_nxt, npr_r, npr_nxt;
  logic [DIM_W-1:0]   crem_r, crem_nxt, rrem_r, rrem_nxt;
  logic [DIM_W-1:0]   ocol_r, ocol_nxt, orow_r, orow_nxt;

  logic               head_start, can_load, item_go;
  logic [POS_W-1:0]   npc_e;
  logic [DIM_W-1:0]   crem_e, ocol_e;
  logic               row_kept, pick, re, fe;
  logic [DIM_W-1:0]   csum, cden, rsum, rden;
  logic [DIM_W-1:0]   short_side, scaled;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    head_start = (q_head.col == '0) && (q_head.row == '0);
    can_load   = !out_valid_r || !out_stall;
    item_go    = (state_r == ST_PIXEL) && !q_empty && can_load
                 && (!head_start || setup_done_r);

    // Column stepper restarts at the first column of every row.
    npc_e  = (q_head.col == '0) ? '0 : npc_r;
    crem_e = (q_head.col == '0) ? '0 : crem_r;
    ocol_e = (q_head.col == '0) ? '0 : ocol_r;

    row_kept = (orow_r < th_r) && (q_head.row == npr_r);
    pick     = row_kept && (ocol_e < tw_r) && (q_head.col == npc_e);
    re       = (ocol_e + DIM_W'(1)) == tw_r;
    fe       = re && ((orow_r + DIM_W'(1)) == th_r);

    cden = tw_r - DIM_W'(1);
    csum = crem_e + DIM_W'(col_rm_r);
    rden = th_r - DIM_W'(1);
    rsum = rrem_r + DIM_W'(row_rm_r);

    short_side = q_head.frame_w >= q_head.frame_h ? q_head.frame_h : q_head.frame_w;
    scaled     = (div_rsp.quot[DIM_W-1:0] == '0) ? DIM_W'(1) : div_rsp.quot[DIM_W-1:0];
  end

  always_comb begin
    state_nxt      = state_r;
    setup_done_nxt = setup_done_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    fw_nxt         = fw_r;
    fh_nxt         = fh_r;
    fb_nxt         = fb_r;
    wide_nxt       = wide_r;
    scale_nxt      = scale_r;
    long_nxt       = long_r;
    prod_nxt       = prod_r;
    tw_nxt         = tw_r;
    th_nxt         = th_r;
    col_q_nxt      = col_q_r;
    col_rm_nxt     = col_rm_r;
    row_q_nxt      = row_q_r;
    row_rm_nxt     = row_rm_r;
    npc_nxt        = npc_r;
    crem_nxt       = crem_r;
    ocol_nxt       = ocol_r;
    npr_nxt        = npr_r;
    rrem_nxt       = rrem_r;
    orow_nxt       = orow_r;
    q_pop          = 1'b0;
    div_req.start  = 1'b0;
    div_req.num    = '0;
    div_req.den    = '0;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_PIXEL: begin
        if (!q_empty && head_start && !setup_done_r) begin
          // First pixel of a frame: latch sizes and form short side times box.
          fw_nxt    = q_head.frame_w;
          fh_nxt    = q_head.frame_h;
          fb_nxt    = q_head.box;
          wide_nxt  = q_head.frame_w >= q_head.frame_h;
          scale_nxt = (q_head.frame_w > q_head.box) || (q_head.frame_h > q_head.box);
          long_nxt  = q_head.frame_w >= q_head.frame_h ? q_head.frame_w : q_head.frame_h;
          prod_nxt  = DIV_NUM_W'(short_side) * DIV_NUM_W'(q_head.box);
          state_nxt = ST_SCALE;
        end else if (item_go) begin
          q_pop    = 1'b1;
          npc_nxt  = npc_e;
          crem_nxt = crem_e;
          ocol_nxt = ocol_e;
          if (pick) begin
            out_valid_nxt          = 1'b1;
            out_data_nxt.blue_out  = premul(q_head.pix.blue_in,  q_head.pix.alpha_in);
            out_data_nxt.green_out = premul(q_head.pix.green_in, q_head.pix.alpha_in);
            out_data_nxt.red_out   = premul(q_head.pix.red_in,   q_head.pix.alpha_in);
            out_data_nxt.alpha_out = q_head.pix.alpha_in;
            out_data_nxt.row_end   = re;
            out_data_nxt.frame_end = fe;
            if (!re) begin
              if (csum >= cden) begin
                crem_nxt = csum - cden;
                npc_nxt  = npc_e + col_q_r + POS_W'(1);
              end else begin
                crem_nxt = csum;
                npc_nxt  = npc_e + col_q_r;
              end
            end
            ocol_nxt = ocol_e + DIM_W'(1);
          end
          if (q_head.last_col && row_kept) begin
            if ((orow_r + DIM_W'(1)) < th_r) begin
              if (rsum >= rden) begin
                rrem_nxt = rsum - rden;
                npr_nxt  = npr_r + row_q_r + POS_W'(1);
              end else begin
                rrem_nxt = rsum;
                npr_nxt  = npr_r + row_q_r;
              end
            end
            orow_nxt = orow_r + DIM_W'(1);
          end
          setup_done_nxt = 1'b0;
        end
      end
      ST_SCALE: begin
        if (scale_r) begin
          div_req.start = 1'b1;
          div_req.num   = {prod_r[DIV_NUM_W-2:0], 1'b0} + DIV_NUM_W'(long_r);
          div_req.den   = {long_r, 1'b0};
          state_nxt     = ST_SCALE_WAIT;
        end else begin
          tw_nxt    = fw_r;
          th_nxt    = fh_r;
          state_nxt = ST_COL;
        end
      end
      ST_SCALE_WAIT: begin
        if (div_rsp.done) begin
          if (wide_r) begin
            tw_nxt = fb_r;
            th_nxt = scaled;
          end else begin
            th_nxt = fb_r;
            tw_nxt = scaled;
          end
          state_nxt = ST_COL;
        end
      end
      ST_COL: begin
        if (tw_r > DIM_W'(1)) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(fw_r - DIM_W'(1));
          div_req.den   = DIV_DEN_W'(tw_r - DIM_W'(1));
          state_nxt     = ST_COL_WAIT;
        end else begin
          col_q_nxt  = '0;
          col_rm_nxt = '0;
          state_nxt  = ST_ROW;
        end
      end
      ST_COL_WAIT: begin
        if (div_rsp.done) begin
          col_q_nxt  = div_rsp.quot[POS_W-1:0];
          col_rm_nxt = div_rsp.rem[POS_W-1:0];
          state_nxt  = ST_ROW;
        end
      end
      ST_ROW: begin
        if (th_r > DIM_W'(1)) begin
          div_req.start = 1'b1;
          div_req.num   = DIV_NUM_W'(fh_r - DIM_W'(1));
          div_req.den   = DIV_DEN_W'(th_r - DIM_W'(1));
          state_nxt     = ST_ROW_WAIT;
        end else begin
          row_q_nxt      = '0;
          row_rm_nxt     = '0;
          npr_nxt        = '0;
          rrem_nxt       = '0;
          orow_nxt       = '0;
          setup_done_nxt = 1'b1;
          state_nxt      = ST_PIXEL;
        end
      end
      ST_ROW_WAIT: begin
        if (div_rsp.done) begin
          row_q_nxt      = div_rsp.quot[POS_W-1:0];
          row_rm_nxt     = div_rsp.rem[POS_W-1:0];
          npr_nxt        = '0;
          rrem_nxt       = '0;
          orow_nxt       = '0;
          setup_done_nxt = 1'b1;
          state_nxt      = ST_PIXEL;
        end
      end
      default: state_nxt = ST_PIXEL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_PIXEL;
      setup_done_r <= 1'b0;
      out_valid_r  <= 1'b0;
      npc_r        <= '0;
      crem_r       <= '0;
      ocol_r       <= '0;
      npr_r        <= '0;
      rrem_r       <= '0;
      orow_r       <= '0;
      tw_r         <= '0;
      th_r         <= '0;
    end else begin
      state_r      <= state_nxt;
      setup_done_r <= setup_done_nxt;
      out_valid_r  <= out_valid_nxt;
      npc_r        <= npc_nxt;
      crem_r       <= crem_nxt;
      ocol_r       <= ocol_nxt;
      npr_r        <= npr_nxt;
      rrem_r       <= rrem_nxt;
      orow_r       <= orow_nxt;
      tw_r         <= tw_nxt;
      th_r         <= th_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    fw_r       <= fw_nxt;
    fh_r       <= fh_nxt;
    fb_r       <= fb_nxt;
    wide_r     <= wide_nxt;
    scale_r    <= scale_nxt;
    long_r     <= long_nxt;
    prod_r     <= prod_nxt;
    col_q_r    <= col_q_nxt;
    col_rm_r   <= col_rm_nxt;
    row_q_r    <= row_q_nxt;
    row_rm_r   <= row_rm_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/core/nearest_downscale_premultiply_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Nearest-neighbor thumbnail downscaler with alpha premultiplication. Source RGBA
// pixels enter in raster order, one request per pixel; the frame position is kept
// internally, so the first request after reset is the top-left pixel of a frame.
// On that first pixel the block latches box_size, source_width and source_height
// (zero counts as one, values above 4096 count as 4096) and works out the target
// size: unchanged if it fits the box, otherwise the long side becomes the box and
// the short side is rounded to nearest, at least one. Only the picked source pixels
// produce a result, as BGRA premultiplied with truncating c*a/255, with row_end and
// frame_end marking the last pixel of a row and of the thumbnail. A configuration
// write takes effect at the next frame start. The block sustains one request per cycle
// while the result side does not stall. The first pixel of each frame waits for frame
// setup, which runs up to three divisions one bit per cycle on a single shared divider
// (size rounding, then the column and row step quotients). A four-entry queue lets the
// input side keep accepting during that setup and during output stalls.
module nearest_downscale_premultiply_unit #(
  parameter int QDEPTH = ndp_pkg::QUEUE_DEPTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire ndp_pkg::pixel_in_t            in_data,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output ndp_pkg::pixel_out_t                out_data,
  input  wire logic                          cfg_we,
  input  wire logic [ndp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ndp_pkg::CFG_W-1:0]     cfg_wdata
);

  import ndp_pkg::*;

  localparam int ENTRY_W = $bits(q_entry_t);

  logic     q_push, q_pop, q_empty, q_full;
  q_entry_t q_wdata, q_head;
  logic [ENTRY_W-1:0] q_rdata;
  div_req_t div_req;
  div_rsp_t div_rsp;

  assign q_head = q_entry_t'(q_rdata);

  // The front tracks the raster position and tags each request with its frame sizes.
  ndp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  ndp_queue #(
    .WIDTH (ENTRY_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .wdata (ENTRY_W'(q_wdata)),
    .pop   (q_pop),
    .rdata (q_rdata),
    .empty (q_empty),
    .full  (q_full)
  );

  // The back runs frame setup, the pick steppers, premultiply and the output register.
  ndp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .div_req   (div_req),
    .div_rsp   (div_rsp)
  );

  ndp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

endmodule

`default_nettype wire

// ===== sim/nearest_downscale_premultiply_unit_tb.sv =====
`timescale 1ns / 1ps

// Testbench for the thumbnail downscaler. Whole frames of random RGBA requests are
// streamed in raster order under a range of box and source sizes. A predictor in this
// module tracks the frame position, works out the target size and the nearest-neighbor
// picks with its own steppers, and queues the premultiplied BGRA pixel for every
// picked request. A checker compares each accepted result with the oldest queued pixel.
module nearest_downscale_premultiply_unit_tb;
  import ndp_pkg::*;

  // The watchdog fires after this many cycles in a row without any handshake.
  // The longest quiet stretch in a correct run is the output hold-off plus the frame
  // setup plus the drain pause before a register write.
  localparam int WATCHDOG_LIMIT = 3000;
  // Cycles allowed after the last expected pixel for requests that produce no pixel.
  localparam int SETTLE_CYCLES  = 150;
  localparam int RANDOM_ITEMS   = 900;
  localparam int HOLD_OFF_LEN   = 300;
  localparam int MAX_REPORTS    = 20;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  pixel_in_t            in_data;
  logic                 out_valid;
  logic                 out_stall;
  pixel_out_t           out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  nearest_downscale_premultiply_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor state. The register copies follow every write; the frame sizes and the
  // stepper quotients are latched from them on the first request of each frame.
  // ---------------------------------------------------------------------------
  pixel_out_t       thumb_pixels_q[$];
  logic [CFG_W-1:0] box_reg;
  logic [CFG_W-1:0] width_reg;
  logic [CFG_W-1:0] height_reg;
  logic [DIM_W-1:0] frm_w;
  logic [DIM_W-1:0] frm_h;
  logic [DIM_W-1:0] tgt_w;
  logic [DIM_W-1:0] tgt_h;
  logic [POS_W-1:0] src_col;
  logic [POS_W-1:0] src_row;
  logic [POS_W-1:0] pick_col;
  logic [POS_W-1:0] pick_row;
  logic [DIM_W-1:0] col_rem;
  logic [DIM_W-1:0] row_rem;
  logic [DIM_W-1:0] dst_col;
  logic [DIM_W-1:0] dst_row;
  logic [DIM_W-1:0] col_step;
  logic [DIM_W-1:0] col_frac;
  logic [DIM_W-1:0] row_step;
  logic [DIM_W-1:0] row_frac;

  // Sender and receiver controls, changed by the tests between phases.
  int  items_sent;
  int  burst_left;
  bit  gaps_on;
  int  stall_mode;
  int  stall_run;
  bit  stalling;
  int  hold_off_left;
  int  mismatches;
  int  quiet_cycles;

  // A register value of zero counts as one, anything above MAX_DIM as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_size(input logic [CFG_W-1:0] v);
    if (v == 0) return DIM_W'(1);
    if (v > MAX_DIM) return DIM_W'(MAX_DIM);
    return v;
  endfunction

  // Short side scaled by box/long, rounded to nearest with integers, at least one.
  function automatic logic [DIM_W-1:0] rounded_side(input logic [DIM_W-1:0] short_side,
                                                    input logic [DIM_W-1:0] box_side,
                                                    input logic [DIM_W-1:0] long_side);
    longint unsigned num;
    longint unsigned quot;
    num  = longint'(short_side) * longint'(box_side) * 2 + longint'(long_side);
    quot = num / (longint'(long_side) * 2);
    return (quot < 1) ? DIM_W'(1) : DIM_W'(quot);
  endfunction

  function automatic pixel_in_t random_pixel();
    pixel_in_t px;
    px.red_in   = 8'($urandom);
    px.green_in = 8'($urandom);
    px.blue_in  = 8'($urandom);
    // Transparent and fully opaque pixels are the interesting ends of the premultiply.
    case ($urandom_range(0, 7))
      0:       px.alpha_in = 8'h00;
      1:       px.alpha_in = 8'hFF;
      default: px.alpha_in = 8'($urandom);
    endcase
    return px;
  endfunction

  // Sizes for the random frames: mostly small, sometimes zero, sometimes larger so
  // that a small box forces a real downscale with uneven steps.
  function automatic logic [CFG_W-1:0] random_dim();
    int unsigned pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) return '0;
    if (pick < 4) return CFG_W'($urandom_range(13, 40));
    return CFG_W'($urandom_range(1, 12));
  endfunction

  // Works out the target size and the column and row steps for a new frame.
  task automatic latch_frame();
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [DIM_W-1:0] b;
    w = clamp_size(width_reg);
    h = clamp_size(height_reg);
    b = clamp_size(box_reg);
    frm_w = w;
    frm_h = h;
    if (w > b || h > b) begin
      if (w >= h) begin
        tgt_w = b;
        tgt_h = rounded_side(h, b, w);
      end else begin
        tgt_h = b;
        tgt_w = rounded_side(w, b, h);
      end
    end else begin
      tgt_w = w;
      tgt_h = h;
    end
    col_step = '0;
    col_frac = '0;
    row_step = '0;
    row_frac = '0;
    if (tgt_w > DIM_W'(1)) begin
      col_step = (w - DIM_W'(1)) / (tgt_w - DIM_W'(1));
      col_frac = (w - DIM_W'(1)) % (tgt_w - DIM_W'(1));
    end
    if (tgt_h > DIM_W'(1)) begin
      row_step = (h - DIM_W'(1)) / (tgt_h - DIM_W'(1));
      row_frac = (h - DIM_W'(1)) % (tgt_h - DIM_W'(1));
    end
    pick_row = '0;
    row_rem  = '0;
    dst_row  = '0;
  endtask

  // Moves a pick position on by quotient plus a carry from the remainder.
  task automatic advance_pick(inout logic [POS_W-1:0] pick, inout logic [DIM_W-1:0] rem,
                              input logic [DIM_W-1:0] step, input logic [DIM_W-1:0] frac,
                              input logic [DIM_W-1:0] den);
    pick = pick + POS_W'(step);
    rem  = rem + frac;
    if (rem >= den) begin
      rem  = rem - den;
      pick = pick + POS_W'(1);
    end
  endtask

  // Runs one accepted request through the predictor and queues the pixel it yields.
  task automatic downscale_pixel(input pixel_in_t px);
    pixel_out_t res;
    bit         row_hit;
    if (src_col == 0 && src_row == 0) latch_frame();
    if (src_col == 0) begin
      pick_col = '0;
      col_rem  = '0;
      dst_col  = '0;
    end
    row_hit = (dst_row < tgt_h) && (src_row == pick_row);
    if (row_hit && dst_col < tgt_w && src_col == pick_col) begin
      res.blue_out  = 8'((32'(px.blue_in) * 32'(px.alpha_in)) / 32'd255);
      res.green_out = 8'((32'(px.green_in) * 32'(px.alpha_in)) / 32'd255);
      res.red_out   = 8'((32'(px.red_in) * 32'(px.alpha_in)) / 32'd255);
      res.alpha_out = px.alpha_in;
      res.row_end   = (dst_col + DIM_W'(1) == tgt_w);
      res.frame_end = res.row_end && (dst_row + DIM_W'(1) == tgt_h);
      thumb_pixels_q.push_back(res);
      if (!res.row_end) begin
        advance_pick(pick_col, col_rem, col_step, col_frac, tgt_w - DIM_W'(1));
      end
      dst_col = dst_col + DIM_W'(1);
    end
    if ({1'b0, src_col} + DIM_W'(1) >= frm_w) begin
      if (row_hit) begin
        if (dst_row + DIM_W'(1) < tgt_h) begin
          advance_pick(pick_row, row_rem, row_step, row_frac, tgt_h - DIM_W'(1));
        end
        dst_row = dst_row + DIM_W'(1);
      end
      src_col = '0;
      if ({1'b0, src_row} + DIM_W'(1) >= frm_h) src_row = '0;
      else src_row = src_row + POS_W'(1);
    end else begin
      src_col = src_col + POS_W'(1);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Offers one request and waits for it to be taken. With gaps on, the sender works
  // in bursts and drops valid for a random number of cycles between them.
  task automatic send_pixel(input pixel_in_t px);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = $urandom_range(1, 20);
      @(negedge clk);
      in_valid = 1'b0;
      in_data  = random_pixel();
      repeat (gap - 1) @(negedge clk);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = px;
    do @(posedge clk); while (in_stall);
    items_sent++;
    downscale_pixel(px);
  endtask

  // Sends whole frames at the current register settings, so the block always ends up
  // back at the top-left position.
  task automatic send_frames(input int count);
    int total;
    total = count * int'(clamp_size(width_reg)) * int'(clamp_size(height_reg));
    repeat (total) send_pixel(random_pixel());
  endtask

  // Register writes happen only from here, with the block idle.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_BOX_SIZE:      box_reg    = val;
      CFG_SOURCE_WIDTH:  width_reg  = val;
      CFG_SOURCE_HEIGHT: height_reg = val;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [CFG_W-1:0] box, input logic [CFG_W-1:0] w,
                           input logic [CFG_W-1:0] h);
    write_reg(CFG_BOX_SIZE, box);
    write_reg(CFG_SOURCE_WIDTH, w);
    write_reg(CFG_SOURCE_HEIGHT, h);
  endtask

  // Stops offering, waits for every predicted pixel, then gives trailing requests that
  // produce no pixel time to leave the block before the registers change.
  task automatic settle();
    @(negedge clk);
    in_valid = 1'b0;
    wait (thumb_pixels_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests.
  // ---------------------------------------------------------------------------

  // Reset settings give 1x1 frames, so every request comes back with both end marks.
  // The channel values walk through the extremes of the premultiply.
  task automatic test_reset_defaults();
    gaps_on    = 1'b0;
    stall_mode = 0;
    send_pixel('{8'h00, 8'h00, 8'h00, 8'h00});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'hFF});
    send_pixel('{8'hFF, 8'hFF, 8'hFF, 8'h00});
    send_pixel('{8'h00, 8'h00, 8'h00, 8'hFF});
    send_pixel('{8'hAA, 8'h55, 8'hAA, 8'h80});
    send_pixel('{8'h55, 8'hAA, 8'h55, 8'h7F});
    settle();
  endtask

  // A 4x3 source in a box of 2 becomes 2x2, so only the four corners are kept and the
  // other requests produce nothing.
  task automatic test_downscale_picks();
    configure(13'd2, 13'd4, 13'd3);
    stall_mode = 1;
    send_frames(1);
    settle();
  endtask

  // A box of zero counts as one: a 3x2 source shrinks to its top-left pixel alone.
  task automatic test_zero_box();
    configure(13'd0, 13'd3, 13'd2);
    gaps_on = 1'b1;
    send_frames(1);
    settle();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering an 8x8
  // frame with no gaps, so the internal queue fills and the input stalls. A second
  // frame follows at once to cover the wrap back to the top-left position.
  task automatic test_output_hold_off();
    configure(13'd256, 13'd8, 13'd8);
    gaps_on    = 1'b0;
    stall_mode = 0;
    @(negedge clk);
    hold_off_left = HOLD_OFF_LEN;
    send_frames(2);
    settle();
  endtask

  // Random settings, each used for one to three back-to-back frames, with the sender
  // gaps and the receiver stall pattern chosen anew for every setting. Near the end of
  // the item budget a frame that would overrun it is cut down to one frame of one row.
  task automatic test_random_frames();
    int               stop_at;
    int               frames;
    int unsigned      pick;
    logic [CFG_W-1:0] box;
    logic [CFG_W-1:0] w;
    logic [CFG_W-1:0] h;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick == 0) box = '0;
      else if (pick == 1) box = $urandom_range(0, 1) ? 13'd4096 : 13'd8191;
      else box = CFG_W'($urandom_range(1, 16));
      w      = random_dim();
      h      = random_dim();
      frames = $urandom_range(1, 3);
      if (frames * int'(clamp_size(w)) * int'(clamp_size(h)) > stop_at - items_sent) begin
        frames = 1;
        h      = CFG_W'(1);
      end
      configure(box, w, h);
      gaps_on    = $urandom_range(0, 2) != 0;
      stall_mode = $urandom_range(0, 2);
      send_frames(frames);
      settle();
    end
  endtask

  // Register values at and past the top of the range. A box of 8191 counts as 4096 and
  // a height of zero as one, so a 6x1 frame fits and every pixel is kept. Then a 1x40
  // source in a box of 5 keeps five rows, with the short side rounding down to zero and
  // being held at one.
  task automatic test_size_limits();
    gaps_on    = 1'b1;
    stall_mode = 1;
    configure(13'd8191, 13'd6, 13'd0);
    send_frames(1);
    settle();
    configure(13'd5, 13'd0, 13'd40);
    stall_mode = 2;
    send_frames(1);
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: either never stalls, or stalls in runs of random length, with a light
  // and a heavy pattern. A hold-off request overrides the pattern and is counted
  // down here on every falling edge.
  // ---------------------------------------------------------------------------
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_stall = 1'b1;
        hold_off_left--;
      end else if (stall_mode == 0) begin
        out_stall = 1'b0;
      end else begin
        if (stall_run == 0) begin
          stall_run = $urandom_range(1, (stall_mode == 1) ? 4 : 16);
          stalling  = $urandom_range(0, 99) < ((stall_mode == 1) ? 30 : 60);
        end
        stall_run--;
        out_stall = stalling;
      end
    end
  end

  task automatic check_field(input string name, input logic [CH_W-1:0] want,
                             input logic [CH_W-1:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Every accepted result is matched against the oldest predicted pixel.
  always @(posedge clk) begin
    pixel_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (thumb_pixels_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: unexpected result, expected none, actual %h", $time, out_data);
      end else begin
        want = thumb_pixels_q.pop_front();
        check_field("blue_out", want.blue_out, out_data.blue_out);
        check_field("green_out", want.green_out, out_data.green_out);
        check_field("red_out", want.red_out, out_data.red_out);
        check_field("alpha_out", want.alpha_out, out_data.alpha_out);
        check_field("row_end", CH_W'(want.row_end), CH_W'(out_data.row_end));
        check_field("frame_end", CH_W'(want.frame_end), CH_W'(out_data.frame_end));
      end
    end
  end

  // Ends the run when neither side has completed a handshake for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_we     = 1'b0;
    cfg_index  = CFG_BOX_SIZE;
    cfg_wdata  = '0;
    box_reg    = BOX_SIZE_RST;
    width_reg  = SOURCE_DIM_RST;
    height_reg = SOURCE_DIM_RST;
    frm_w      = 0;
    frm_h      = 0;
    tgt_w      = 0;
    tgt_h      = 0;
    src_col    = 0;
    src_row    = 0;
    pick_col   = 0;
    pick_row   = 0;
    col_rem    = 0;
    row_rem    = 0;
    dst_col    = 0;
    dst_row    = 0;
    col_step   = 0;
    col_frac   = 0;
    row_step   = 0;
    row_frac   = 0;
    items_sent    = 0;
    burst_left    = 0;
    gaps_on       = 1'b0;
    stall_mode    = 0;
    stall_run     = 0;
    stalling      = 1'b0;
    hold_off_left = 0;
    mismatches    = 0;
    quiet_cycles  = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_reset_defaults();
    test_downscale_picks();
    test_zero_box();
    test_output_hold_off();
    test_random_frames();
    test_size_limits();

    wait (thumb_pixels_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== nearest_downscale_premultiply_unit.f =====
rtl/core/ndp_pkg.sv
rtl/core/ndp_queue.sv
rtl/core/ndp_front.sv
rtl/core/ndp_div.sv
rtl/core/ndp_back.sv
rtl/core/nearest_downscale_premultiply_unit.sv
sim/nearest_downscale_premultiply_unit_tb.sv
